[sv/ggse_pkg.sv]
// ----------------------------------------------------------------------------
// ggse_pkg
// shared constants and types of the grid gradient step engine
// ----------------------------------------------------------------------------
`default_nettype none

package ggse_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int COORD_W = 6;
    localparam int VALUE_W = 32;
    localparam int GRAD_W  = 33;
    localparam int DVD_W   = 64;
    localparam int DSR_W   = 33;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_STEP_SIZE   = 1'b0;
    localparam logic REG_SMALL_SCALE = 1'b1;

    localparam logic [31:0] STEP_SIZE_RST   = 32'd65536;
    localparam logic [31:0] SMALL_SCALE_RST = 32'd1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ABSENT     = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;
    localparam logic [1:0] STATUS_FALLBACK   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DVD_W-1:0]  quotient;
    } div_sts_t;

endpackage

`default_nettype wire

[sv/ggse_cell_ram.sv]
// ----------------------------------------------------------------------------
// ggse_cell_ram
// single port write, single port read cell memory, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ggse_cell_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 33
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[sv/ggse_divider.sv]
// ----------------------------------------------------------------------------
// ggse_divider
// restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ggse_divider
    import ggse_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_sts_t      sts
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = dvd_reg;

endmodule

`default_nettype wire

[sv/grid_gradient_step_engine.sv]
// ----------------------------------------------------------------------------
// grid_gradient_step_engine
// grid of q16.16 navigation values with upwind gradient and scaled step query
//
//   channel  | direction | handshake       | payload
//   s_       | in        | s_valid/s_ready | s_command, s_x, s_y, s_value
//   m_       | out       | m_valid/m_ready | m_status, m_grad_x/y, m_step_x/y
//   cfg_     | in        | cfg_wr_en       | cfg_index, cfg_wdata
//
// a write is stored as it is taken; a full query steps through the neighbor reads,
// the gradient, two squares and a sum, a square root and three divisions; an
// absent or incomplete query returns right after the gradient, a zero norm after
// the square root, a too small scale after the first division
// reset starts a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells, s_ready low
// a finished result waits in the output register while the next transaction
// is taken; a query holds in its last state while the divider runs or that register stays full
// ----------------------------------------------------------------------------
`default_nettype none

module grid_gradient_step_engine
    import ggse_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_command,
    input  wire logic [COORD_W-1:0]        s_x,
    input  wire logic [COORD_W-1:0]        s_y,
    input  wire logic [VALUE_W-1:0]        s_value,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [1:0]                     m_status,
    output logic signed [GRAD_W-1:0]       m_grad_x,
    output logic signed [GRAD_W-1:0]       m_grad_y,
    output logic signed [GRAD_W-1:0]       m_step_x,
    output logic signed [GRAD_W-1:0]       m_step_y,
    input  wire logic                      cfg_wr_en,
    input  wire logic                      cfg_index,
    input  wire logic [31:0]               cfg_wdata
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NC_W  = COORD_W + 1;

    typedef enum logic [15:0] {
        ST_CLEAR      = 16'b0000_0000_0000_0001,
        ST_IDLE       = 16'b0000_0000_0000_0010,
        ST_READ       = 16'b0000_0000_0000_0100,
        ST_GRAD       = 16'b0000_0000_0000_1000,
        ST_SQX        = 16'b0000_0000_0001_0000,
        ST_SQY        = 16'b0000_0000_0010_0000,
        ST_SUM        = 16'b0000_0000_0100_0000,
        ST_SQRT       = 16'b0000_0000_1000_0000,
        ST_ALPHA_GO   = 16'b0000_0001_0000_0000,
        ST_ALPHA_WAIT = 16'b0000_0010_0000_0000,
        ST_MULX       = 16'b0000_0100_0000_0000,
        ST_DIVX_GO    = 16'b0000_1000_0000_0000,
        ST_DIVX_WAIT  = 16'b0001_0000_0000_0000,
        ST_MULY       = 16'b0010_0000_0000_0000,
        ST_DIVY_GO    = 16'b0100_0000_0000_0000,
        ST_DIVY_WAIT  = 16'b1000_0000_0000_0000
    } state_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] g;
        logic                     hit;
    } axis_t;

    function automatic axis_t axis_grad(
        input logic [31:0] base,
        input logic        lo_p,
        input logic [31:0] lo_v,
        input logic        hi_p,
        input logic [31:0] hi_v
    );
        logic signed [33:0] dl;
        logic signed [33:0] dh;
        logic signed [33:0] sum;
        logic [1:0]         n;
        axis_t              r;
        dl  = $signed({2'b00, base}) - $signed({2'b00, lo_v});
        dh  = $signed({2'b00, hi_v}) - $signed({2'b00, base});
        sum = '0;
        n   = 2'd0;
        if (lo_p && dl > 34'sd0) begin
            sum = sum + dl;
            n   = n + 2'd1;
        end
        if (hi_p && dh < 34'sd0) begin
            sum = sum + dh;
            n   = n + 2'd1;
        end
        if (n == 2'd2) begin
            sum = (sum + (sum[33] ? 34'sd1 : 34'sd0)) >>> 1;
        end
        r.g   = sum[GRAD_W-1:0];
        r.hit = (n != 2'd0);
        return r;
    endfunction

    function automatic logic signed [GRAD_W-1:0] half_by_sign(
        input logic signed [GRAD_W-1:0] g,
        input logic [31:0]              step
    );
        logic signed [GRAD_W-1:0] h;
        h = $signed({2'b00, step[31:1]});
        if (g > 0) begin
            return h;
        end else if (g < 0) begin
            return -h;
        end
        return '0;
    endfunction

    state_t state_reg, state_next;

    logic [31:0]               step_size_reg;
    logic [31:0]               small_scale_reg;

    logic [AW-1:0]             clr_cnt_reg;
    logic [COORD_W-1:0]        q_x_reg;
    logic [COORD_W-1:0]        q_y_reg;
    logic [2:0]                rd_cnt_reg;
    logic [2:0]                tap_reg;
    logic                      tap_vld_reg;
    logic                      tap_on_reg;
    logic [31:0]               val_reg [5];
    logic [4:0]                pres_reg;

    logic [1:0]                st_reg;
    logic signed [GRAD_W-1:0]  gx_reg;
    logic signed [GRAD_W-1:0]  gy_reg;
    logic signed [GRAD_W-1:0]  sx_reg;
    logic signed [GRAD_W-1:0]  sy_reg;
    logic [63:0]               prod_reg;
    logic [63:0]               acc_reg;
    logic                      sx_done_reg;

    logic [65:0]               sq_rad_reg;
    logic [33:0]               sq_rem_reg;
    logic [32:0]               sq_root_reg;
    logic [5:0]                sq_cnt_reg;

    logic                      m_valid_reg;
    logic [1:0]                m_status_reg;
    logic signed [GRAD_W-1:0]  m_grad_x_reg;
    logic signed [GRAD_W-1:0]  m_grad_y_reg;
    logic signed [GRAD_W-1:0]  m_step_x_reg;
    logic signed [GRAD_W-1:0]  m_step_y_reg;

    logic                      s_accept;
    logic                      in_on_grid;
    logic                      issue;
    logic [NC_W-1:0]           ncx;
    logic [NC_W-1:0]           ncy;
    logic                      n_under;
    logic                      n_on_grid;
    logic [AW-1:0]             rd_addr;
    logic [32:0]               rd_data;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [32:0]               ram_wdata;
    axis_t                     ax_x;
    axis_t                     ax_y;
    logic [GRAD_W-1:0]         abs_x;
    logic [GRAD_W-1:0]         abs_y;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic [35:0]               sq_sh;
    logic [35:0]               sq_trial;
    logic                      sq_ge;
    div_req_t                  div_req;
    div_sts_t                  div_sts;
    logic signed [GRAD_W-1:0]  q_signed;
    logic signed [GRAD_W-1:0]  sy_final;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // cell coordinate of the current read: center, x-1, x+1, y-1, y+1
    always_comb begin
        ncx     = {1'b0, q_x_reg};
        ncy     = {1'b0, q_y_reg};
        n_under = 1'b0;
        case (rd_cnt_reg)
            3'd1: begin
                ncx     = NC_W'(q_x_reg) - 1'b1;
                n_under = (q_x_reg == '0);
            end
            3'd2: begin
                ncx = NC_W'(q_x_reg) + 1'b1;
            end
            3'd3: begin
                ncy     = NC_W'(q_y_reg) - 1'b1;
                n_under = (q_y_reg == '0);
            end
            3'd4: begin
                ncy = NC_W'(q_y_reg) + 1'b1;
            end
            default: begin
                ncx = {1'b0, q_x_reg};
            end
        endcase
    end

    assign n_on_grid = !n_under && (32'(ncx) < 32'(GRID_WIDTH))
                       && (32'(ncy) < 32'(GRID_HEIGHT));
    assign rd_addr   = AW'(32'(ncy) * 32'(GRID_WIDTH) + 32'(ncx));
    assign issue     = (state_reg == ST_READ) && (rd_cnt_reg <= 3'd4);

    assign in_on_grid = (32'(s_x) < 32'(GRID_WIDTH)) && (32'(s_y) < 32'(GRID_HEIGHT));

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s_accept && (s_command == CMD_WRITE) && in_on_grid;
            ram_waddr = AW'(32'(s_y) * 32'(GRID_WIDTH) + 32'(s_x));
            ram_wdata = {1'b1, s_value};
        end
    end

    ggse_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (33)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ax_x = axis_grad(val_reg[0], pres_reg[1], val_reg[1], pres_reg[2], val_reg[2]);
    assign ax_y = axis_grad(val_reg[0], pres_reg[3], val_reg[3], pres_reg[4], val_reg[4]);

    assign abs_x = gx_reg[GRAD_W-1] ? GRAD_W'(-gx_reg) : GRAD_W'(gx_reg);
    assign abs_y = gy_reg[GRAD_W-1] ? GRAD_W'(-gy_reg) : GRAD_W'(gy_reg);

    // one shared multiplier, product registered
    always_comb begin
        case (state_reg)
            ST_SQX: begin
                mul_a = abs_x[31:0];
                mul_b = abs_x[31:0];
            end
            ST_SQY: begin
                mul_a = abs_y[31:0];
                mul_b = abs_y[31:0];
            end
            ST_MULX: begin
                mul_a = abs_x[31:0];
                mul_b = step_size_reg;
            end
            default: begin
                mul_a = abs_y[31:0];
                mul_b = step_size_reg;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // square root, two radicand bits per cycle
    assign sq_sh    = {sq_rem_reg, sq_rad_reg[65:64]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign div_req.start    = (state_reg == ST_ALPHA_GO) || (state_reg == ST_DIVX_GO)
                              || (state_reg == ST_DIVY_GO);
    assign div_req.dividend = (state_reg == ST_ALPHA_GO) ?
                              {16'b0, step_size_reg, 16'b0} : prod_reg;
    assign div_req.divisor  = sq_root_reg;

    ggse_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .sts     (div_sts)
    );

    assign q_signed = $signed({1'b0, div_sts.quotient[31:0]});

    // y step as it stands at the end of the query, including the quotient just in
    assign sy_final = (div_sts.done && sx_done_reg) ?
                      (gy_reg[GRAD_W-1] ? -q_signed : q_signed) : sy_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept && s_command == CMD_QUERY) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (tap_vld_reg && tap_reg == 3'd4) begin
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD: begin
                if (!pres_reg[0] || !ax_x.hit || !ax_y.hit) begin
                    state_next = ST_DIVY_WAIT;
                end else begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_cnt_reg == 6'd32) begin
                    state_next = ({sq_root_reg[31:0], sq_ge} == '0) ? ST_DIVY_WAIT
                                                                   : ST_ALPHA_GO;
                end
            end
            ST_ALPHA_GO: state_next = ST_ALPHA_WAIT;
            ST_ALPHA_WAIT: begin
                if (div_sts.done) begin
                    state_next = (div_sts.quotient < {32'b0, small_scale_reg}) ?
                                 ST_DIVY_WAIT : ST_MULX;
                end
            end
            ST_MULX:     state_next = ST_DIVX_GO;
            ST_DIVX_GO:  state_next = ST_DIVX_WAIT;
            ST_DIVX_WAIT: begin
                if (div_sts.done) begin
                    state_next = ST_MULY;
                end
            end
            ST_MULY:     state_next = ST_DIVY_GO;
            ST_DIVY_GO:  state_next = ST_DIVY_WAIT;
            ST_DIVY_WAIT: begin
                // done once the last division is in or the query ended early, output free
                if (!div_sts.busy && !div_req.start && (!m_valid_reg || m_ready)
                    && !(st_reg == STATUS_OK && !sx_done_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            step_size_reg   <= STEP_SIZE_RST;
            small_scale_reg <= SMALL_SCALE_RST;
            rd_cnt_reg      <= 3'd5;
            tap_vld_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            sx_done_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STEP_SIZE:   step_size_reg   <= cfg_wdata;
                    REG_SMALL_SCALE: small_scale_reg <= cfg_wdata;
                    default:         step_size_reg   <= step_size_reg;
                endcase
            end
            if (s_accept && s_command == CMD_QUERY) begin
                rd_cnt_reg <= 3'd0;
            end else if (issue) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            tap_vld_reg <= issue;
            if (state_reg == ST_GRAD) begin
                sx_done_reg <= 1'b0;
            end else if (state_reg == ST_DIVY_GO) begin
                sx_done_reg <= 1'b1;
            end
            if (state_reg == ST_DIVY_WAIT && state_next == ST_IDLE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            q_x_reg <= s_x;
            q_y_reg <= s_y;
        end
        tap_reg    <= rd_cnt_reg;
        tap_on_reg <= n_on_grid;
        if (tap_vld_reg) begin
            val_reg[tap_reg]  <= rd_data[31:0];
            pres_reg[tap_reg] <= tap_on_reg && rd_data[32];
        end
        if (state_reg == ST_SQX || state_reg == ST_SQY || state_reg == ST_MULX
            || state_reg == ST_MULY) begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_SQY) begin
            acc_reg <= prod_reg;
        end
        if (state_reg == ST_SUM) begin
            sq_rad_reg  <= 66'(acc_reg) + 66'(prod_reg);
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end else if (state_reg == ST_SQRT) begin
            sq_rad_reg  <= {sq_rad_reg[63:0], 2'b00};
            sq_rem_reg  <= sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
            sq_root_reg <= {sq_root_reg[31:0], sq_ge};
            sq_cnt_reg  <= sq_cnt_reg + 1'b1;
        end
        case (state_reg)
            ST_GRAD: begin
                if (!pres_reg[0]) begin
                    st_reg <= STATUS_ABSENT;
                    gx_reg <= '0;
                    gy_reg <= '0;
                    sx_reg <= '0;
                    sy_reg <= '0;
                end else begin
                    gx_reg <= ax_x.g;
                    gy_reg <= ax_y.g;
                    if (ax_x.hit && ax_y.hit) begin
                        st_reg <= STATUS_FALLBACK;
                        sx_reg <= '0;
                        sy_reg <= '0;
                    end else begin
                        st_reg <= STATUS_INCOMPLETE;
                        sx_reg <= half_by_sign(ax_x.g, step_size_reg);
                        sy_reg <= half_by_sign(ax_y.g, step_size_reg);
                    end
                end
            end
            ST_ALPHA_WAIT: begin
                if (div_sts.done) begin
                    if (div_sts.quotient < {32'b0, small_scale_reg}) begin
                        sx_reg <= half_by_sign(gx_reg, step_size_reg);
                        sy_reg <= half_by_sign(gy_reg, step_size_reg);
                    end else begin
                        st_reg <= STATUS_OK;
                    end
                end
            end
            ST_DIVX_WAIT: begin
                if (div_sts.done) begin
                    sx_reg <= gx_reg[GRAD_W-1] ? -q_signed : q_signed;
                end
            end
            ST_DIVY_WAIT: begin
                sy_reg <= sy_final;
            end
            default: begin
                st_reg <= st_reg;
            end
        endcase
        if (state_reg == ST_DIVY_WAIT && state_next == ST_IDLE) begin
            m_status_reg <= st_reg;
            m_grad_x_reg <= gx_reg;
            m_grad_y_reg <= gy_reg;
            m_step_x_reg <= sx_reg;
            m_step_y_reg <= sy_final;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_grad_x = m_grad_x_reg;
    assign m_grad_y = m_grad_y_reg;
    assign m_step_x = m_step_x_reg;
    assign m_step_y = m_step_y_reg;

    ast_no_write_during_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !ram_we)
        else $error("cell memory written during neighbor reads");

    ast_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_ABSENT) |->
        (m_grad_x == '0 && m_grad_y == '0 && m_step_x == '0 && m_step_y == '0))
        else $error("absent cell transaction carries nonzero fields");

    ast_div_idle_at_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVY_WAIT && state_next == ST_IDLE) |-> !div_sts.busy)
        else $error("result issued while divider still running");

    ast_ok_step_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_status == STATUS_OK |->
        (m_step_x <= $signed({1'b0, step_size_reg})
         && m_step_x >= -$signed({1'b0, step_size_reg})))
        else $error("scaled step exceeds step length");

    ast_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

`default_nettype wire
